@@ src/qmhq_pkg.sv @@
// Shared types and codes for the quaternary min-heap queue.
// Depends on nothing; imported by every other file of the block.
package qmhq_pkg;

	// One stored heap entry: node tag over priority (unsigned Q16.16)
	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] prio;
	} entry_t;

	// Four children per node: child index is pos*4+1, parent (pos-1)/4
	localparam int ARITY      = 4;
	localparam int ARITY_LOG2 = 2;

	// Request opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_PUSH_OK = 2'd0;
	localparam logic [1:0] ST_POP_OK  = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_POP_ROOT,
		S_POP_LAST,
		S_UP_HEAD,
		S_UP_CMP,
		S_DN_HEAD,
		S_DN_SCAN,
		S_DN_CMP,
		S_RESULT
	} state_t;

endpackage

@@ src/qmhq_ram.sv @@
// Heap entry store: one write port, one read port with registered read data.
// Depends on qmhq_pkg for the entry type.
module qmhq_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  qmhq_pkg::entry_t  wr_data,
	input  logic [AW-1:0]     rd_addr,
	output qmhq_pkg::entry_t  rd_data
);
	import qmhq_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/quaternary_min_heap_queue.sv @@
// Quaternary min-heap priority queue: a push inserts a tagged entry and sifts
// it up, a pop returns the smallest entry and sifts the last one down. Each
// request gives exactly one result. One request is worked at a time and the
// input stalls until its result has moved into the output register. All
// heap traffic goes through a single-read, single-write entry memory and one
// shared 32-bit priority comparator, so the cost is set by memory reads: a
// push reads one parent per level moved up, a pop reads the children of
// each level moved down (up to four). Full and empty cases go straight to
// the result state. Ties keep the first smallest child.
// Depends on qmhq_pkg and qmhq_ram.
module quaternary_min_heap_queue #(
	parameter int CAPACITY = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] node_in,
	input  logic [31:0] priority_in,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] node_out,
	output logic [31:0] priority_out,
	output logic [10:0] occupancy
);
	import qmhq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 3;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   pos_q, par_q, cidx_q, best_idx_q;
	entry_t          item_q, root_q, best_q;
	logic            first_pick_q;
	logic [1:0]      res_status_q;

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [15:0]     node_q;
	logic [31:0]     prio_q;
	logic [10:0]     occ_q;

	// memory port
	logic            wr_en;
	logic [AW-1:0]   wr_addr, rd_addr;
	entry_t          wr_data, rd_data;

	// shared comparator
	logic [31:0]     cmp_a, cmp_b;
	logic            lt;

	// index arithmetic
	logic            accept, out_free, is_full, is_empty;
	logic [CW-1:0]   cnt_m1;
	logic [AW-1:0]   parent;
	logic [XW-1:0]   first_x, size_x, end_x, next_x, lim_x;
	logic            child_ok, more;

	qmhq_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// handshake and counters
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign cnt_m1   = count_q - CW'(1);

	// heap index math
	assign parent   = AW'((pos_q - AW'(1)) >> ARITY_LOG2);
	assign first_x  = (XW'(pos_q) << ARITY_LOG2) + XW'(1);
	assign size_x   = XW'(count_q);
	assign child_ok = (first_x < size_x);
	assign lim_x    = first_x + XW'(ARITY);
	assign end_x    = (lim_x > size_x) ? size_x : lim_x;
	assign next_x   = XW'(cidx_q) + XW'(1);
	assign more     = (next_x < end_x);

	assign lt = (cmp_a < cmp_b);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_PUSH) begin
						state_d = is_full ? S_RESULT : S_UP_HEAD;
					end else begin
						state_d = is_empty ? S_RESULT : S_POP_ROOT;
					end
				end
			end
			S_POP_ROOT: state_d = S_POP_LAST;
			S_POP_LAST: state_d = (count_q == CW'(1)) ? S_RESULT : S_DN_HEAD;
			S_UP_HEAD:  state_d = (pos_q == '0) ? S_RESULT : S_UP_CMP;
			S_UP_CMP:   state_d = lt ? S_UP_HEAD : S_RESULT;
			S_DN_HEAD:  state_d = child_ok ? S_DN_SCAN : S_RESULT;
			S_DN_SCAN:  state_d = more ? S_DN_SCAN : S_DN_CMP;
			S_DN_CMP:   state_d = lt ? S_DN_HEAD : S_RESULT;
			S_RESULT:   state_d = out_free ? S_IDLE : S_RESULT;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory and comparator controls
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = item_q;
		cmp_a   = item_q.prio;
		cmp_b   = rd_data.prio;
		unique case (state_q)
			S_POP_ROOT: rd_addr = cnt_m1[AW-1:0];
			S_UP_HEAD: begin
				rd_addr = parent;
				wr_en   = (pos_q == '0);
			end
			S_UP_CMP: begin
				wr_en   = 1'b1;
				wr_data = lt ? rd_data : item_q;
			end
			S_DN_HEAD: begin
				rd_addr = first_x[AW-1:0];
				wr_en   = !child_ok;
			end
			S_DN_SCAN: begin
				rd_addr = next_x[AW-1:0];
				cmp_a   = rd_data.prio;
				cmp_b   = best_q.prio;
			end
			S_DN_CMP: begin
				cmp_a   = best_q.prio;
				cmp_b   = item_q.prio;
				wr_en   = 1'b1;
				wr_data = lt ? best_q : item_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && opcode == OP_PUSH && !is_full) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_POP_LAST) begin
				count_q <= cnt_m1;
			end
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the sift walk
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q.tag  <= node_in;
					item_q.prio <= priority_in;
					pos_q       <= count_q[AW-1:0];
					if (opcode == OP_PUSH) begin
						res_status_q <= is_full ? ST_FULL : ST_PUSH_OK;
					end else begin
						res_status_q <= is_empty ? ST_EMPTY : ST_POP_OK;
					end
				end
			end
			S_POP_ROOT: root_q <= rd_data;
			S_POP_LAST: begin
				item_q <= rd_data;
				pos_q  <= '0;
			end
			S_UP_HEAD: par_q <= parent;
			S_UP_CMP: begin
				if (lt) begin
					pos_q <= par_q;
				end
			end
			S_DN_HEAD: begin
				cidx_q       <= first_x[AW-1:0];
				first_pick_q <= 1'b1;
			end
			S_DN_SCAN: begin
				// keep the first smallest child
				if (first_pick_q || lt) begin
					best_q     <= rd_data;
					best_idx_q <= cidx_q;
				end
				first_pick_q <= 1'b0;
				cidx_q       <= next_x[AW-1:0];
			end
			S_DN_CMP: begin
				if (lt) begin
					pos_q <= best_idx_q;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			status_q <= res_status_q;
			node_q   <= (res_status_q == ST_POP_OK) ? root_q.tag  : 16'd0;
			prio_q   <= (res_status_q == ST_POP_OK) ? root_q.prio : 32'd0;
			occ_q    <= 11'(count_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign node_out     = node_q;
	assign priority_out = prio_q;
	assign occupancy    = occ_q;

endmodule

@@ src/qmhq_checker.sv @@
// Port-level checks for the quaternary min-heap queue, with its bind.
// Depends on qmhq_pkg and the top level quaternary_min_heap_queue.
module qmhq_checker #(
	parameter int CAPACITY = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] node_out,
	input logic [31:0] priority_out,
	input logic [10:0] occupancy
);
	import qmhq_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(node_out)
			&& $stable(priority_out) && $stable(occupancy))
		else $error("stalled result changed");

	// only a returned entry carries a tag and priority
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_PUSH_OK || status == ST_EMPTY || status == ST_FULL)
			|-> node_out == 16'd0 && priority_out == 32'd0)
		else $error("nonzero payload on non-pop result");

	// empty report means nothing held
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == 11'd0)
		else $error("empty status with nonzero occupancy");

	// full report means store at capacity
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupancy == 11'(CAPACITY))
		else $error("full status below capacity");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

endmodule

bind quaternary_min_heap_queue qmhq_checker #(
	.CAPACITY (CAPACITY)
) u_qmhq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.node_out     (node_out),
	.priority_out (priority_out),
	.occupancy    (occupancy)
);

@@ sim/testbench.sv @@
// Testbench for quaternary_min_heap_queue: drives push and pop requests and checks
// every result against a mirrored four-ary heap kept in a small class.
// Depends on qmhq_pkg and the block's RTL.
`timescale 1ns / 100ps

// Mirror of the heap contents; predicts the result of each accepted request
class heap_mirror #(int DEPTH = 1024);
	typedef struct {
		logic [1:0]  status;
		logic [15:0] node;
		logic [31:0] prio;
		logic [10:0] occupancy;
	} heap_result_t;

	qmhq_pkg::entry_t slots [0:DEPTH-1];
	int unsigned      count;
	heap_result_t     pending_results [$];
	int unsigned      errors;
	int unsigned      checked;

	function new();
		count   = 0;
		errors  = 0;
		checked = 0;
	endfunction

	function int unsigned pending();
		return pending_results.size();
	endfunction

	// Push: move the new entry up while strictly below its parent
	function void sift_in(qmhq_pkg::entry_t e);
		int unsigned pos;
		int unsigned up;
		bit          moving;
		pos    = count;
		count++;
		moving = 1'b1;
		while (moving && pos > 0) begin
			up = (pos - 1) / qmhq_pkg::ARITY;
			if (e.prio < slots[up].prio) begin
				slots[pos] = slots[up];
				pos        = up;
			end else begin
				moving = 1'b0;
			end
		end
		slots[pos] = e;
	endfunction

	// Pop: the last entry walks down through the first smallest child
	function qmhq_pkg::entry_t take_root();
		qmhq_pkg::entry_t root;
		qmhq_pkg::entry_t tail;
		int unsigned      pos;
		int unsigned      first;
		int unsigned      best;
		bit               moving;
		root = slots[0];
		tail = slots[count-1];
		count--;
		if (count > 0) begin
			pos    = 0;
			moving = 1'b1;
			while (moving) begin
				first = pos * qmhq_pkg::ARITY + 1;
				if (first >= count) begin
					moving = 1'b0;
				end else begin
					best = first;
					for (int unsigned c = first + 1;
					     c < first + qmhq_pkg::ARITY && c < count; c++) begin
						if (slots[c].prio < slots[best].prio)
							best = c;
					end
					if (slots[best].prio < tail.prio) begin
						slots[pos] = slots[best];
						pos        = best;
					end else begin
						moving = 1'b0;
					end
				end
			end
			slots[pos] = tail;
		end
		return root;
	endfunction

	// Note an accepted request and queue the result it must produce
	function void apply_request(logic op, logic [15:0] node, logic [31:0] prio);
		heap_result_t     r;
		qmhq_pkg::entry_t e;
		r.node = '0;
		r.prio = '0;
		if (op == qmhq_pkg::OP_PUSH) begin
			if (count >= DEPTH) begin
				r.status = qmhq_pkg::ST_FULL;
			end else begin
				e.tag    = node;
				e.prio   = prio;
				sift_in(e);
				r.status = qmhq_pkg::ST_PUSH_OK;
			end
		end else begin
			if (count == 0) begin
				r.status = qmhq_pkg::ST_EMPTY;
			end else begin
				e        = take_root();
				r.status = qmhq_pkg::ST_POP_OK;
				r.node   = e.tag;
				r.prio   = e.prio;
			end
		end
		r.occupancy = count[10:0];
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Compare one delivered result with the oldest pending one
	function void check_result(logic [1:0] status, logic [15:0] node, logic [31:0] prio,
			logic [10:0] occupancy);
		heap_result_t r;
		checked++;
		if (pending_results.size() == 0) begin
			$display("%0t: result with no request pending: status %0d node %h prio %h occ %0d",
				$time, status, node, prio, occupancy);
			errors++;
			return;
		end
		r = pending_results[0];
		pending_results.delete(0);
		if (status !== r.status) begin
			$display("%0t: status expected %0d actual %0d", $time, r.status, status);
			errors++;
		end
		if (node !== r.node) begin
			$display("%0t: node_out expected %h actual %h", $time, r.node, node);
			errors++;
		end
		if (prio !== r.prio) begin
			$display("%0t: priority_out expected %h actual %h", $time, r.prio, prio);
			errors++;
		end
		if (occupancy !== r.occupancy) begin
			$display("%0t: occupancy expected %0d actual %0d", $time, r.occupancy, occupancy);
			errors++;
		end
	endfunction
endclass

module testbench;
	import qmhq_pkg::*;

	localparam int HEAP_DEPTH  = 1024;
	localparam int CYCLE_LIMIT = 1000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [15:0] node_in;
	logic [31:0] priority_in;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [15:0] node_out;
	logic [31:0] priority_out;
	logic [10:0] occupancy;

	heap_mirror #(HEAP_DEPTH) mirror;
	int unsigned burst_left;
	int unsigned cycle_count;

	quaternary_min_heap_queue #(.CAPACITY(HEAP_DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.node_in      (node_in),
		.priority_in  (priority_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.node_out     (node_out),
		.priority_out (priority_out),
		.occupancy    (occupancy)
	);

	// Clock, period 8 ns
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.check_result(status, node_out, priority_out, occupancy);
	end

	// Receiver: stall patterns that change now and then, plus two long hold-offs
	initial begin : receiver
		int unsigned pattern_left;
		int unsigned stall_pct;
		int unsigned holdoff_left;
		int unsigned holdoffs_done;
		pattern_left  = 0;
		stall_pct     = 0;
		holdoff_left  = 0;
		holdoffs_done = 0;
		out_stall     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((holdoffs_done == 0 && mirror.checked >= 40) ||
			    (holdoffs_done == 1 && mirror.checked >= 900)) begin
				holdoff_left = 400;
				holdoffs_done++;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_stall <= 1'b1;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(10, 80);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				pattern_left--;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Offer one request; gaps fall between bursts of random length
	task automatic send_request(input logic op, input logic [15:0] node,
			input logic [31:0] prio);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 30);
		end
		burst_left--;
		in_valid    <= 1'b1;
		opcode      <= op;
		node_in     <= node;
		priority_in <= prio;
		do @(posedge clk); while (in_stall);
		mirror.apply_request(op, node, prio);
	endtask

	// Hold the request channel idle until every result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	// Priorities mix full range, extremes and a narrow set that forces ties
	function automatic logic [31:0] pick_priority();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5: return $urandom_range(0, 7);
			6: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
			default: return {8'h00, 8'($urandom_range(0, 255)), 16'h0000};
		endcase
	endfunction

	function automatic logic [15:0] pick_node();
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic random_request(input int unsigned push_pct);
		if ($urandom_range(0, 99) < push_pct)
			send_request(OP_PUSH, pick_node(), pick_priority());
		else
			send_request(OP_POP, pick_node(), pick_priority());
	endtask

	// Main sequence
	initial begin : stimulus
		int unsigned full_rejects;
		mirror      = new();
		burst_left  = 0;
		cycle_count = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_PUSH;
		node_in     = '0;
		priority_in = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pop on empty, field extremes, equal priorities, drain past empty
		send_request(OP_POP, 16'h0000, 32'h0000_0000);
		send_request(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(OP_PUSH, 16'h0000, 32'h0000_0000);
		send_request(OP_PUSH, 16'h1234, 32'h0001_0000);
		send_request(OP_PUSH, 16'h0005, 32'h0001_0000);
		send_request(OP_PUSH, 16'h0006, 32'h0001_0000);
		send_request(OP_PUSH, 16'h0007, 32'h0000_8000);
		send_request(OP_PUSH, 16'hAAAA, 32'h5555_5555);
		send_request(OP_PUSH, 16'h5555, 32'hAAAA_AAAA);
		repeat (9) send_request(OP_POP, 16'hFFFF, 32'hFFFF_FFFF);
		wait_drained();

		// Mixed traffic around a small heap, empty pops included
		repeat (450) random_request((mirror.count > 40) ? 40 : 55);
		wait_drained();

		// Fill to capacity, hit the full case a few times, then pop deep heaps
		full_rejects = 0;
		while (full_rejects < 4) begin
			if (mirror.count == HEAP_DEPTH && $urandom_range(0, 99) < 95)
				full_rejects++;
			if (mirror.count == HEAP_DEPTH)
				send_request(OP_PUSH, pick_node(), pick_priority());
			else
				random_request(95);
		end
		repeat (80) random_request(10);

		// Wind down
		wait_drained();
		repeat (60) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
